[hw/rtl/fba_pkg.sv]
`default_nettype none

package fba_pkg;

	localparam int NUM_FRAMES = 32768;
	localparam int WORD_BITS  = 32;
	localparam int NUM_WORDS  = NUM_FRAMES / WORD_BITS;
	localparam int WORD_AW    = $clog2(NUM_WORDS);
	// One bit more than the word address so that a word count can reach NUM_WORDS.
	localparam int WORD_CW    = WORD_AW + 1;
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int FRAME_W    = 15;
	localparam int ADDR_W     = 32;
	localparam int PAGE_SHIFT = 12;
	localparam int CFG_W      = 16;

	localparam logic [CFG_W-1:0]     FRAME_COUNT_RESET = 16'h8000;
	localparam logic [WORD_BITS-1:0] FULL_WORD         = '1;

	typedef enum logic [1:0] {
		REQ_ALLOC = 2'd0,
		REQ_FREE  = 2'd1,
		REQ_MARK  = 2'd2,
		REQ_TEST  = 2'd3
	} req_type_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [ADDR_W-1:0]  frame_address;
		logic [FRAME_W-1:0] page_frame;
		logic               kernel_page;
		logic               write_access;
		logic               ignore_existing;
	} fba_in_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic               present;
		logic               writable;
		logic               user_mode;
		logic               page_changed;
		logic               frame_used;
		logic               out_of_frames;
	} fba_out_t;

	// Position of the lowest clear bit of a word; the word must not be all ones.
	function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
		logic [BIT_W-1:0] pos;
		pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				pos = BIT_W'(i);
			end
		end
		return pos;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/frame_bitmap_allocator.sv]
`default_nettype none

// First-fit page frame allocator. The used/free bitmap of 32768 frames sits in
// a 1024 x 32 synchronous RAM. After reset the block first sweeps the RAM to
// zero, one word per cycle, and keeps req_stall high until the sweep is done;
// frame_count may be written only while no request is in flight. Free,
// mark-used and test requests have two steps: one to read the bitmap word, one
// to evaluate it and write it back, which waits until the output register is
// free. Allocate reads from a low-water word pointer, below which every word is
// known to be full, and walks upward one word per cycle until it finds a word
// with a clear bit; the pointer moves with it, so the walk stays short in
// normal use. Free moves the pointer back down when it releases a frame below
// it. Only one request is in flight; a finished result sits in an output
// register, so the next request is taken while the previous beat is still
// stalled on rsp.
module frame_bitmap_allocator
	import fba_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,

	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire fba_in_t          req_beat,

	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output fba_out_t              rsp_beat,

	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata
);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EVAL  = 3'b100
	} state_t;

	state_t               state_q;
	logic [WORD_AW-1:0]   clr_cnt_q;
	logic [WORD_CW-1:0]   lo_q;       // every word below this one is full
	logic [WORD_CW-1:0]   cur_w_q;    // word under inspection by allocate
	logic [CFG_W-1:0]     frame_count_q;
	fba_in_t              req_q;
	logic                 rsp_valid_q;
	fba_out_t             rsp_q;

	logic                 accept;
	logic                 out_free;
	logic                 scan_step;
	logic                 done;
	logic                 commit;

	logic                 ram_we;
	logic [WORD_AW-1:0]   ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [WORD_AW-1:0]   ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	logic                 ev_we;
	logic [WORD_AW-1:0]   ev_waddr;
	logic [WORD_BITS-1:0] ev_wdata;
	logic [WORD_CW-1:0]   ev_lo;
	fba_out_t             ev_rsp;

	logic [WORD_CW-1:0]   limit;
	logic [WORD_CW-1:0]   cur_next;
	logic [BIT_W-1:0]     zero_pos;
	logic [WORD_BITS-1:0] alloc_word;
	logic                 alloc_skip;
	logic                 addr_in_range;
	logic [WORD_AW-1:0]   addr_word;
	logic [BIT_W-1:0]     addr_bit;
	logic [WORD_AW-1:0]   pf_word;
	logic [BIT_W-1:0]     pf_bit;

	fba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(NUM_WORDS)
	) u_bitmap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Handshake. The block takes a request only in IDLE; the output register
	// decouples the result from the downstream stall.
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && (state_q == ST_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_beat  = rsp_q;

	// Only whole words below frame_count are searched, never past the bitmap end.
	assign limit = (frame_count_q[CFG_W-1:BIT_W] > WORD_CW'(NUM_WORDS)) ?
		WORD_CW'(NUM_WORDS) : WORD_CW'(frame_count_q[CFG_W-1:BIT_W]);

	assign cur_next = cur_w_q + 1'b1;

	// Address decoding for the live request (used at accept) and the held one.
	always_comb begin
		fba_in_t src;
		src           = (state_q == ST_IDLE) ? req_beat : req_q;
		addr_in_range = (src.frame_address[ADDR_W-1:PAGE_SHIFT+FRAME_W] == '0);
		addr_word     = src.frame_address[PAGE_SHIFT+FRAME_W-1:PAGE_SHIFT+BIT_W];
		addr_bit      = src.frame_address[PAGE_SHIFT+BIT_W-1:PAGE_SHIFT];
		pf_word       = src.page_frame[FRAME_W-1:BIT_W];
		pf_bit        = src.page_frame[BIT_W-1:0];
	end

	// Read port: the first word at accept, the next word on each allocate step.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		if (accept) begin
			ram_re = 1'b1;
			unique case (req_beat.req_type)
				REQ_ALLOC: ram_raddr = lo_q[WORD_AW-1:0];
				REQ_FREE:  ram_raddr = pf_word;
				REQ_MARK,
				REQ_TEST:  ram_raddr = addr_word;
				default:   ram_raddr = '0;
			endcase
		end else if (scan_step) begin
			ram_re    = 1'b1;
			ram_raddr = cur_next[WORD_AW-1:0];
		end
	end

	assign zero_pos   = first_zero(ram_rdata);
	assign alloc_word = ram_rdata | (WORD_BITS'(1) << zero_pos);
	assign alloc_skip = (req_q.page_frame != '0) && !req_q.ignore_existing;

	// Evaluation of the word just read. The default result leaves the page
	// entry alone: frame echoes the request and the entry bits are clear.
	always_comb begin
		scan_step          = 1'b0;
		ev_we              = 1'b0;
		ev_waddr           = cur_w_q[WORD_AW-1:0];
		ev_wdata           = ram_rdata;
		ev_lo              = lo_q;
		ev_rsp             = '0;
		ev_rsp.frame       = req_q.page_frame;

		unique case (req_q.req_type)
			REQ_ALLOC: begin
				if (!alloc_skip) begin
					if (cur_w_q >= limit) begin
						ev_rsp.out_of_frames = 1'b1;
					end else if (ram_rdata != FULL_WORD) begin
						ev_we               = 1'b1;
						ev_wdata            = alloc_word;
						ev_lo               = (alloc_word == FULL_WORD) ? cur_next : cur_w_q;
						ev_rsp.frame        = {cur_w_q[WORD_AW-1:0], zero_pos};
						ev_rsp.present      = 1'b1;
						ev_rsp.writable     = req_q.write_access;
						ev_rsp.user_mode    = !req_q.kernel_page;
						ev_rsp.page_changed = 1'b1;
					end else begin
						// Full word: step to the next one and raise the pointer.
						scan_step = 1'b1;
						ev_lo     = cur_next;
					end
				end
			end
			REQ_FREE: begin
				if (req_q.page_frame != '0) begin
					ev_we               = 1'b1;
					ev_waddr            = pf_word;
					ev_wdata            = ram_rdata & ~(WORD_BITS'(1) << pf_bit);
					ev_rsp.frame        = '0;
					ev_rsp.page_changed = 1'b1;
					if (WORD_CW'(pf_word) < lo_q) begin
						ev_lo = WORD_CW'(pf_word);
					end
				end
			end
			REQ_MARK: begin
				if (addr_in_range) begin
					ev_we    = 1'b1;
					ev_waddr = addr_word;
					ev_wdata = ram_rdata | (WORD_BITS'(1) << addr_bit);
				end
			end
			REQ_TEST: begin
				ev_rsp.frame_used = addr_in_range && ram_rdata[addr_bit];
			end
			default: ;
		endcase

		if (state_q != ST_EVAL) begin
			scan_step = 1'b0;
		end
	end

	// A finished request commits its write only once the output register is
	// free; until then the read data is simply held.
	assign done   = (state_q == ST_EVAL) && !scan_step;
	assign commit = done && out_free;

	// Write port: the clearing sweep after reset, otherwise the evaluation.
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else begin
			ram_we    = commit && ev_we;
			ram_waddr = ev_waddr;
			ram_wdata = ev_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_cnt_q     <= '0;
			lo_q          <= '0;
			cur_w_q       <= '0;
			frame_count_q <= FRAME_COUNT_RESET;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				frame_count_q <= cfg_wdata;
			end

			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == WORD_AW'(NUM_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						cur_w_q <= lo_q;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (scan_step) begin
						cur_w_q <= cur_next;
						lo_q    <= ev_lo;
					end else if (commit) begin
						lo_q    <= ev_lo;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_beat;
		end
		if (commit) begin
			rsp_q <= ev_rsp;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/fba_ram.sv]
`default_nettype none

module fba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read data holds its value until the next read is issued.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
